### sv/mlcd_pkg.sv
`timescale 1ns / 1ps

package mlcd_pkg;

  localparam int PANEL_WIDTH_DEF  = 400;
  localparam int PANEL_HEIGHT_DEF = 240;

  // request codes
  localparam logic [2:0] REQ_DRAW   = 3'd0;
  localparam logic [2:0] REQ_CLEAR  = 3'd1;
  localparam logic [2:0] REQ_TOGGLE = 3'd2;
  localparam logic [2:0] REQ_START  = 3'd3;
  localparam logic [2:0] REQ_LINE   = 3'd4;
  localparam logic [2:0] REQ_END    = 3'd5;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WRITE_CMD = 2'd0;
  localparam logic [1:0] REG_VCOM_BIT  = 2'd1;
  localparam logic [1:0] REG_CLEAR_CMD = 2'd2;

  localparam logic [7:0] WRITE_CMD_RST = 8'd128;
  localparam logic [7:0] VCOM_BIT_RST  = 8'd64;
  localparam logic [7:0] CLEAR_CMD_RST = 8'd32;

  localparam logic [7:0] WHITE_BYTE = 8'hFF;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  typedef struct packed {
    logic [2:0] req_type;
    logic [9:0] column;
    logic [7:0] row;
    logic       pixel_on;
  } req_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       opens_select;
    logic       closes_select;
    logic       last_of_run;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_CMD,
    ST_TAIL,
    ST_LINE_HDR,
    ST_LINE_DATA
  } state_t;

  function automatic logic [7:0] flip_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

endpackage

### sv/memory_lcd_frame_controller_top.sv
`timescale 1ns / 1ps

// Draw: one frame store read, then the masked write back.
// Line: header, ROW_BYTES store bytes, zero; one byte per cycle while the output is not stalled.
// Toggle/clear: command byte, then a zero byte; frame start: command byte; frame end: zero byte;
//   each byte is valid the cycle after it is loaded, and a stalled output holds the sequencer.
// Reset is synchronous; after reset and after each clear a fill pass writes 0xFF to all
//   ROW_BYTES*PANEL_HEIGHT bytes before a new word is taken.
module memory_lcd_frame_controller_top #(
  parameter int PANEL_WIDTH  = mlcd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mlcd_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  mlcd_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output mlcd_pkg::rsp_word_t rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mlcd_pkg::*;

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CNT_W       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(ROW_BYTES - 1);

  state_t state, state_next;

  logic [7:0] write_cmd, vcom_bit, clear_cmd;
  logic       vcom;

  logic [2:0]        req_q;
  logic [7:0]        row_q;
  logic [2:0]        col_lo;
  logic              pix_on;
  logic [ADDR_W-1:0] addr, addr_calc;
  logic [CNT_W-1:0]  cnt;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata;
  logic       mem_re, mem_we;
  logic [7:0] mem_wdata;

  logic      accept, out_free, out_load, pix_ok, line_ok;
  rsp_word_t out_next;
  logic [7:0] vbits, cmd_byte, mask;

  assign accept   = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;
  assign pix_ok   = ({1'b0, req.column} < 11'(PANEL_WIDTH)) &&
                    ({1'b0, req.row} < 9'(PANEL_HEIGHT));
  assign line_ok  = {1'b0, req.row} < 9'(PANEL_HEIGHT);
  assign addr_calc = ADDR_W'(ADDR_W'(req.row) * ADDR_W'(ROW_BYTES)) +
                     ((req.req_type == REQ_DRAW) ? ADDR_W'(req.column[9:3]) : '0);

  assign vbits = vcom ? vcom_bit : ZERO_BYTE;
  assign mask  = 8'h80 >> col_lo;

  always_comb begin
    case (req_q)
      REQ_CLEAR: cmd_byte = clear_cmd | vbits;
      REQ_START: cmd_byte = write_cmd | vbits;
      default:   cmd_byte = vbits;  // toggle: level already flipped
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP: begin
        if (addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          case (req.req_type) inside
            REQ_DRAW:                        state_next = pix_ok ? ST_PIX_RD : ST_IDLE;
            REQ_CLEAR, REQ_TOGGLE, REQ_START: state_next = ST_CMD;
            REQ_LINE:                        state_next = line_ok ? ST_LINE_HDR : ST_IDLE;
            REQ_END:                         state_next = ST_TAIL;
            default:                         state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD: state_next = ST_PIX_WR;
      ST_PIX_WR: state_next = ST_IDLE;
      ST_CMD: begin
        if (out_free) state_next = (req_q == REQ_START) ? ST_IDLE : ST_TAIL;
      end
      ST_TAIL: begin
        if (out_free) state_next = (req_q == REQ_CLEAR) ? ST_SWEEP : ST_IDLE;
      end
      ST_LINE_HDR: begin
        if (out_free) state_next = ST_LINE_DATA;
      end
      ST_LINE_DATA: begin
        if (out_free && cnt == LAST_CNT) state_next = ST_TAIL;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_ready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = WHITE_BYTE;
    out_load  = 1'b0;
    out_next  = '0;
    unique case (state)
      ST_SWEEP: mem_we = 1'b1;
      ST_IDLE:  req_ready = 1'b1;
      ST_PIX_RD: mem_re = 1'b1;
      ST_PIX_WR: begin
        mem_we    = 1'b1;
        mem_wdata = pix_on ? (rdata & ~mask) : (rdata | mask);
      end
      ST_CMD: begin
        out_load              = out_free;
        out_next.out_byte     = cmd_byte;
        out_next.opens_select = 1'b1;
        out_next.last_of_run  = (req_q == REQ_START);
      end
      ST_TAIL: begin
        out_load               = out_free;
        out_next.out_byte      = ZERO_BYTE;
        out_next.closes_select = (req_q != REQ_LINE);
        out_next.last_of_run   = 1'b1;
      end
      ST_LINE_HDR: begin
        out_load          = out_free;
        out_next.out_byte = flip_byte(row_q + 8'd1);
        mem_re            = out_free;
      end
      ST_LINE_DATA: begin
        out_load          = out_free;
        out_next.out_byte = flip_byte(rdata);
        mem_re            = out_free && (cnt != LAST_CNT);
      end
      default: ;
    endcase
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wdata;
    if (mem_re) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      addr  <= '0;
      cnt   <= '0;
      vcom  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        addr <= addr_calc;
        cnt  <= '0;
        if (req.req_type == REQ_TOGGLE) vcom <= ~vcom;
      end else if (state == ST_SWEEP) begin
        addr <= addr + ADDR_W'(1);
      end else if (state == ST_TAIL && out_free && req_q == REQ_CLEAR) begin
        addr <= '0;
      end else if (mem_re && state != ST_PIX_RD) begin
        addr <= addr + ADDR_W'(1);
      end
      if (state == ST_LINE_DATA && out_free) cnt <= cnt + CNT_W'(1);
    end
  end

  // request word fields kept for the run
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req.req_type;
      row_q  <= req.row;
      col_lo <= req.column[2:0];
      pix_on <= req.pixel_on;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) rsp <= out_next;
  end

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_cmd <= WRITE_CMD_RST;
      vcom_bit  <= VCOM_BIT_RST;
      clear_cmd <= CLEAR_CMD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WRITE_CMD: write_cmd <= pwdata[7:0];
        REG_VCOM_BIT:  vcom_bit  <= pwdata[7:0];
        REG_CLEAR_CMD: clear_cmd <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WRITE_CMD: prdata = 32'(write_cmd);
      REG_VCOM_BIT:  prdata = 32'(vcom_bit);
      REG_CLEAR_CMD: prdata = 32'(clear_cmd);
      default:       prdata = '0;
    endcase
  end

endmodule

### sv/mlcd_checker.sv
`timescale 1ns / 1ps

module mlcd_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input mlcd_pkg::req_word_t req,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input mlcd_pkg::rsp_word_t rsp,
  input logic                pready
);
  import mlcd_pkg::*;

  // a result word stays until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  // the fill pass after reset blocks new words
  a_rst_fill: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("word taken during post-reset fill");

  // a pixel draw never produces a word
  a_draw_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.req_type == REQ_DRAW && !rsp_valid |=> !rsp_valid)
    else $error("draw produced a result word");

  // no single word both opens and closes select
  a_select_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.opens_select && rsp.closes_select))
    else $error("word opens and closes select");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind memory_lcd_frame_controller_top mlcd_checker u_mlcd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp),
  .pready    (pready)
);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mlcd_pkg::*;

  localparam int PANEL_W = PANEL_WIDTH_DEF;
  localparam int PANEL_H = PANEL_HEIGHT_DEF;
  localparam int ROW_BYTES = (PANEL_W + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_H;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 16;

  // request codes the block has no use for
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_word_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_word_t rsp;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // predicted panel state
  logic [7:0] pixel_store [0:STORE_BYTES-1];
  logic vcom_lvl;
  logic [7:0] cfg_write_cmd;
  logic [7:0] cfg_vcom_bit;
  logic [7:0] cfg_clear_cmd;
  rsp_word_t pending_bytes[$];

  int err_count = 0;
  int bytes_checked = 0;
  int cycle_count = 0;
  int n_draws = 0;
  int n_lines = 0;
  int n_clears = 0;
  int n_requests = 0;
  int n_reg_writes = 0;
  int rsp_hold_cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  memory_lcd_frame_controller_top dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still pending", cycle_count,
               pending_bytes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] t;
    t = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
    t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
    t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
    return t;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input bit op, input bit cl,
                                     input bit last);
    rsp_word_t w;
    w.out_byte = b;
    w.opens_select = op;
    w.closes_select = cl;
    w.last_of_run = last;
    pending_bytes.push_back(w);
  endfunction

  function automatic void whiten_store();
    for (int i = 0; i < STORE_BYTES; i++) pixel_store[i] = WHITE_BYTE;
  endfunction

  // updates the panel state for one accepted word and queues the bytes it sends
  task automatic predict_request(input req_word_t w);
    logic [7:0] vb;
    logic [7:0] mask;
    int idx;
    int base;
    vb = vcom_lvl ? cfg_vcom_bit : ZERO_BYTE;
    n_requests++;
    case (w.req_type)
      REQ_DRAW: begin
        if (w.column < PANEL_W && w.row < PANEL_H) begin
          idx = w.row * ROW_BYTES + (w.column >> 3);
          mask = 8'h80 >> w.column[2:0];
          if (w.pixel_on) pixel_store[idx] = pixel_store[idx] & ~mask;
          else pixel_store[idx] = pixel_store[idx] | mask;
        end
        n_draws++;
      end
      REQ_CLEAR: begin
        queue_byte(cfg_clear_cmd | vb, 1'b1, 1'b0, 1'b0);
        queue_byte(ZERO_BYTE, 1'b0, 1'b1, 1'b1);
        whiten_store();
        n_clears++;
      end
      REQ_TOGGLE: begin
        vcom_lvl = ~vcom_lvl;
        queue_byte(vcom_lvl ? cfg_vcom_bit : ZERO_BYTE, 1'b1, 1'b0, 1'b0);
        queue_byte(ZERO_BYTE, 1'b0, 1'b1, 1'b1);
      end
      REQ_START: queue_byte(cfg_write_cmd | vb, 1'b1, 1'b0, 1'b1);
      REQ_LINE: begin
        if (w.row < PANEL_H) begin
          queue_byte(mirror8(w.row + 8'd1), 1'b0, 1'b0, 1'b0);
          base = w.row * ROW_BYTES;
          for (int i = 0; i < ROW_BYTES; i++)
            queue_byte(mirror8(pixel_store[base + i]), 1'b0, 1'b0, 1'b0);
          queue_byte(ZERO_BYTE, 1'b0, 1'b0, 1'b1);
          n_lines++;
        end
      end
      REQ_END: queue_byte(ZERO_BYTE, 1'b0, 1'b1, 1'b1);
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch on %s at byte %0d: got %0h, want %0h", what, bytes_checked, got,
               want);
  endtask

  always @(posedge clk) begin : check_bytes
    rsp_word_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected word", rsp.out_byte, 0);
      end else begin
        want = pending_bytes.pop_front();
        if (rsp.out_byte !== want.out_byte)
          report_mismatch("out_byte", rsp.out_byte, want.out_byte);
        if (rsp.opens_select !== want.opens_select)
          report_mismatch("opens_select", rsp.opens_select, want.opens_select);
        if (rsp.closes_select !== want.closes_select)
          report_mismatch("closes_select", rsp.closes_select, want.closes_select);
        if (rsp.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", rsp.last_of_run, want.last_of_run);
      end
      bytes_checked++;
    end
  end

  // output side: random stalls per word, or one long hold when asked
  initial begin : rsp_side
    int n;
    rsp_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_hold_cycles > 0) begin
        n = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end else begin
        n = rx_idle_on ? $urandom_range(0, 18) : 0;
      end
      if (n > 0) begin
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_ready));
    end
  end

  // valid stays up after acceptance; the next send or idle_sender decides its level
  task automatic send_req(input logic [2:0] kind, input int col, input int r, input bit on);
    req_word_t w;
    int gap;
    w.req_type = kind;
    w.column = col[9:0];
    w.row = r[7:0];
    w.pixel_on = on;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!(req_valid && req_ready === 1'b1));
    predict_request(w);
  endtask

  task automatic send_any(input logic [2:0] kind);
    send_req(kind, $urandom_range(0, 1023), $urandom_range(0, 255),
             1'($urandom_range(0, 1)));
  endtask

  task automatic idle_sender();
    req_valid <= 1'b0;
  endtask

  task automatic settle();
    idle_sender();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_WRITE_CMD: cfg_write_cmd = val;
      REG_VCOM_BIT: cfg_vcom_bit = val;
      REG_CLEAR_CMD: cfg_clear_cmd = val;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    n_reg_writes++;
  endtask

  task automatic write_regs(input logic [7:0] wr, input logic [7:0] vc, input logic [7:0] cl);
    settle();
    write_reg(REG_WRITE_CMD, wr);
    write_reg(REG_VCOM_BIT, vc);
    write_reg(REG_CLEAR_CMD, cl);
  endtask

  // reset values of the command registers, vcom on and off
  task automatic test_default_commands();
    send_any(REQ_TOGGLE);
    send_any(REQ_START);
    send_any(REQ_END);
    send_any(REQ_TOGGLE);
    send_any(REQ_START);
    send_any(REQ_END);
  endtask

  task automatic test_pixel_edges();
    send_req(REQ_DRAW, 0, 0, 1'b1);
    send_req(REQ_DRAW, PANEL_W - 1, 0, 1'b1);
    send_req(REQ_DRAW, 0, PANEL_H - 1, 1'b1);
    send_req(REQ_DRAW, PANEL_W - 1, PANEL_H - 1, 1'b1);
    send_req(REQ_DRAW, 9, 0, 1'b1);
    send_req(REQ_DRAW, 9, 0, 1'b0);
    send_req(REQ_DRAW, 10, 0, 1'b1);
    // off-panel draws must leave the store alone
    send_req(REQ_DRAW, 1023, 255, 1'b1);
    send_req(REQ_DRAW, PANEL_W, 0, 1'b1);
    send_req(REQ_DRAW, 0, PANEL_H, 1'b1);
    send_req(REQ_LINE, 1023, 0, 1'b1);
    send_req(REQ_LINE, 0, PANEL_H - 1, 1'b0);
    send_req(REQ_LINE, 0, PANEL_H, 1'b0);
    send_req(REQ_LINE, 0, 255, 1'b0);
    send_any(REQ_SPARE_LO);
    send_any(REQ_SPARE_HI);
  endtask

  task automatic test_clear_refill();
    send_any(REQ_CLEAR);
    send_req(REQ_LINE, 0, 0, 1'b0);
  endtask

  // long output hold while lines keep coming, then a full drain before going on
  task automatic test_output_stall();
    settle();
    tx_idle_on = 1'b0;
    rsp_hold_cycles = 400;
    send_any(REQ_START);
    repeat (4) send_req(REQ_LINE, 0, $urandom_range(0, PANEL_H - 1), 1'b0);
    send_any(REQ_END);
    settle();
    send_any(REQ_TOGGLE);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int done;
    int clears;
    int phase;
    int cnt;
    int hot_row;
    int r;
    done = 0;
    clears = 0;
    phase = 0;
    hot_row = $urandom_range(0, PANEL_H - 1);
    while (done < 120) begin
      if (done >= phase * 40) begin
        case (phase)
          0: write_regs(8'h00, 8'h00, 8'h00);
          1: write_regs(8'hFF, 8'hFF, 8'hFF);
          default: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
        endcase
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
        phase++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          cnt = $urandom_range(1, 6);
          repeat (cnt) begin
            r = ($urandom_range(0, 9) < 7) ? hot_row : $urandom_range(0, PANEL_H - 1);
            send_req(REQ_DRAW, $urandom_range(0, PANEL_W - 1), r,
                     1'($urandom_range(0, 1)));
          end
          done += cnt;
        end
        4, 5, 6: begin
          send_any(REQ_START);
          cnt = $urandom_range(1, 3);
          repeat (cnt) begin
            r = ($urandom_range(0, 9) < 6) ? hot_row : $urandom_range(0, PANEL_H - 1);
            send_req(REQ_LINE, $urandom_range(0, 1023), r, 1'($urandom_range(0, 1)));
          end
          send_any(REQ_END);
          done += cnt + 2;
          hot_row = $urandom_range(0, PANEL_H - 1);
        end
        7: begin
          send_any(REQ_TOGGLE);
          done++;
        end
        8: begin
          case ($urandom_range(0, 3))
            0: send_req(REQ_DRAW, $urandom_range(PANEL_W, 1023), $urandom_range(0, 255),
                        1'($urandom_range(0, 1)));
            1: send_req(REQ_DRAW, $urandom_range(0, 1023), $urandom_range(PANEL_H, 255),
                        1'($urandom_range(0, 1)));
            2: send_req(REQ_LINE, $urandom_range(0, 1023), $urandom_range(PANEL_H, 255),
                        1'($urandom_range(0, 1)));
            default: send_any($urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO);
          endcase
        end
        default: begin
          // clears are slow (full store sweep), keep them few
          if (clears < 3 && $urandom_range(0, 2) == 0) begin
            send_any(REQ_CLEAR);
            clears++;
            done++;
          end else if ($urandom_range(0, 1)) begin
            send_any(REQ_START);
            send_any(REQ_END);
            done += 2;
          end else begin
            send_req(REQ_LINE, $urandom_range(0, 1023), hot_row, 1'($urandom_range(0, 1)));
            send_any(REQ_END);
            done += 2;
          end
        end
      endcase
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    whiten_store();
    vcom_lvl = 1'b0;
    cfg_write_cmd = WRITE_CMD_RST;
    cfg_vcom_bit = VCOM_BIT_RST;
    cfg_clear_cmd = CLEAR_CMD_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_default_commands();
    test_pixel_edges();
    test_clear_refill();
    test_output_stall();
    test_random_traffic();

    idle_sender();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests sent: %0d draws, %0d lines, %0d clears; %0d register writes",
             n_requests, n_draws, n_lines, n_clears, n_reg_writes);
    $display("%0d output words checked, %0d mismatches, %0d cycles", bytes_checked,
             err_count, cycle_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
